// ===== design/raster_draw_engine_assert.svh =====
// Assertion macros for the checker file of the draw engine.
`ifndef RASTER_DRAW_ENGINE_ASSERT_SVH
`define RASTER_DRAW_ENGINE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define RDE_ASSERT_IMP(LBL, CLK, RSTN, A, C) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |-> (C)) \
    else $error("rde check failed: same-cycle property");

// Next-cycle implication, off while reset is held.
`define RDE_ASSERT_NXT(LBL, CLK, RSTN, A, C) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |=> (C)) \
    else $error("rde check failed: next-cycle property");

// Next-cycle implication that also runs during reset.
`define RDE_ASSERT_RST(LBL, CLK, A, C) \
  LBL: assert property (@(posedge CLK) (A) |=> (C)) \
    else $error("rde check failed: reset property");

`endif

// ===== design/rde_pkg.sv =====
package rde_pkg;

  localparam int KIND_BITS       = 3;
  localparam int DIM_BITS        = 13;
  localparam int PITCH_BITS      = 16;
  localparam int ADDR_BITS       = 32;
  localparam int COLOR_BITS      = 32;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int PIX_SHIFT       = $clog2(BYTES_PER_PIXEL);

  localparam int CMD_DEPTH    = 2;
  localparam int RES_DEPTH    = 4;
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FB_BASE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FB_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FB_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_PITCH = 2'd3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_TICK  = 3'd0,
    KIND_PIXEL = 3'd1,
    KIND_HLINE = 3'd2,
    KIND_VLINE = 3'd3,
    KIND_RECT  = 3'd4,
    KIND_FILL  = 3'd5,
    KIND_LINE  = 3'd6,
    KIND_CLEAR = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_FILL    = 4'b0010,
    MODE_OUTLINE = 4'b0100,
    MODE_LINE    = 4'b1000
  } mode_t;

  typedef enum logic [1:0] {
    SEG_TOP    = 2'd0,
    SEG_BOTTOM = 2'd1,
    SEG_LEFT   = 2'd2,
    SEG_RIGHT  = 2'd3
  } seg_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  base;
    logic [DIM_BITS-1:0]   width;
    logic [DIM_BITS-1:0]   height;
    logic [PITCH_BITS-1:0] pitch;
  } cfg_t;

  // Decoded control part of one queued transaction.
  typedef struct packed {
    logic       is_tick;
    mode_t      mode;
    seg_t       first_seg;
    logic       hpos;
    logic [1:0] signs;
  } rec_ctl_t;

  typedef struct packed {
    logic                  write_enable;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  done_res;
  } res_t;

endpackage

// ===== design/rde_fifo.sv =====
module rde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/rde_front.sv =====
module rde_front #(
  parameter int COORD_BITS = 16
) (
  input  logic [rde_pkg::KIND_BITS-1:0]   kind,
  input  logic signed [COORD_BITS-1:0]    start_x,
  input  logic signed [COORD_BITS-1:0]    start_y,
  input  logic signed [COORD_BITS-1:0]    end_x,
  input  logic signed [COORD_BITS-1:0]    end_y,
  input  logic signed [COORD_BITS-1:0]    extent_w,
  input  logic signed [COORD_BITS-1:0]    extent_h,
  input  logic [rde_pkg::COLOR_BITS-1:0]  paint,
  input  rde_pkg::cfg_t                   cfg,
  output rde_pkg::rec_ctl_t               ctl,
  output logic [rde_pkg::COLOR_BITS-1:0]  color,
  output logic signed [COORD_BITS+1:0]    ax,
  output logic signed [COORD_BITS+1:0]    ay,
  output logic signed [COORD_BITS+1:0]    bx,
  output logic signed [COORD_BITS+1:0]    by,
  output logic [COORD_BITS-1:0]           sdx,
  output logic [COORD_BITS-1:0]           sdy
);

  import rde_pkg::*;

  localparam int CW = COORD_BITS + 2;
  localparam int XW = CW - COORD_BITS;
  localparam logic signed [CW-1:0] ONE = CW'(1);

  kind_t                k;
  mode_t                rmode;
  logic signed [CW-1:0] sx, sy, ex, ey, w, h;
  logic signed [CW-1:0] ox, oy, rw, rh, dx, dy, adx, ady;
  logic                 wpos, hpos, empty;

  assign sx = {{XW{start_x[COORD_BITS-1]}}, start_x};
  assign sy = {{XW{start_y[COORD_BITS-1]}}, start_y};
  assign ex = {{XW{end_x[COORD_BITS-1]}}, end_x};
  assign ey = {{XW{end_y[COORD_BITS-1]}}, end_y};
  assign w  = {{XW{extent_w[COORD_BITS-1]}}, extent_w};
  assign h  = {{XW{extent_h[COORD_BITS-1]}}, extent_h};

  assign k     = kind_t'(kind);
  assign color = paint;

  // Reduce every box command to an origin and a size.
  always_comb begin
    ox    = sx;
    oy    = sy;
    rw    = ONE;
    rh    = ONE;
    rmode = MODE_FILL;
    unique case (k)
      KIND_TICK, KIND_PIXEL, KIND_LINE: begin
      end
      KIND_HLINE: rw = w;
      KIND_VLINE: rh = h;
      KIND_RECT: begin
        rw    = w;
        rh    = h;
        rmode = MODE_OUTLINE;
      end
      KIND_FILL: begin
        rw = w;
        rh = h;
      end
      KIND_CLEAR: begin
        ox = '0;
        oy = '0;
        rw = CW'(cfg.width);
        rh = CW'(cfg.height);
      end
      default: begin
      end
    endcase
  end

  assign wpos  = !rw[CW-1] && (rw != '0);
  assign hpos  = !rh[CW-1] && (rh != '0);
  // An outline survives if either pair of sides has positive length.
  assign empty = (rmode == MODE_OUTLINE) ? !(wpos || hpos) : !(wpos && hpos);

  assign dx  = ex - sx;
  assign dy  = ey - sy;
  assign adx = dx[CW-1] ? -dx : dx;
  assign ady = dy[CW-1] ? -dy : dy;
  assign sdx = adx[COORD_BITS-1:0];
  assign sdy = ady[COORD_BITS-1:0];

  always_comb begin
    ctl.is_tick   = (k == KIND_TICK);
    ctl.first_seg = (rmode == MODE_OUTLINE && !wpos) ? SEG_LEFT : SEG_TOP;
    ctl.hpos      = hpos;
    ctl.signs[0]  = dx[CW-1] || (dx == '0);
    ctl.signs[1]  = dy[CW-1] || (dy == '0);
    if (k == KIND_LINE) begin
      ctl.mode = MODE_LINE;
      ax       = sx;
      ay       = sy;
      bx       = ex;
      by       = ey;
    end else begin
      ctl.mode = empty ? MODE_IDLE : rmode;
      ax       = ox;
      ay       = oy;
      bx       = ox + rw - ONE;
      by       = oy + rh - ONE;
    end
  end

endmodule

// ===== design/rde_back.sv =====
module rde_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rde_pkg::cfg_t                     cfg,
  input  logic                              q_valid,
  input  rde_pkg::rec_ctl_t                 q_ctl,
  input  logic [rde_pkg::COLOR_BITS-1:0]    q_color,
  input  logic signed [COORD_BITS+1:0]      q_ax,
  input  logic signed [COORD_BITS+1:0]      q_ay,
  input  logic signed [COORD_BITS+1:0]      q_bx,
  input  logic signed [COORD_BITS+1:0]      q_by,
  input  logic [COORD_BITS-1:0]             q_sdx,
  input  logic [COORD_BITS-1:0]             q_sdy,
  output logic                              q_pop,
  input  logic [rde_pkg::RES_CNT_BITS-1:0]  res_count,
  output logic                              res_valid,
  output rde_pkg::res_t                     res
);

  import rde_pkg::*;

  localparam int CW = COORD_BITS + 2;
  localparam int EW = COORD_BITS + 3;
  localparam int PB = RES_CNT_BITS + 1;
  localparam logic signed [CW-1:0] ONE = CW'(1);

  // Walker state
  mode_t                mode_r, mode_nxt;
  seg_t                 seg_r, seg_nxt;
  logic signed [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CW-1:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic signed [CW-1:0] far_x_r, far_x_nxt, far_y_r, far_y_nxt;
  logic [COORD_BITS-1:0] sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic [1:0]           signs_r, signs_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic                 hpos_r, hpos_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;

  // Pixel pipeline
  logic                  v1_r, on1_r, done1_r;
  logic [DIM_BITS-1:0]   px1_r, py1_r;
  logic [COLOR_BITS-1:0] color1_r;
  logic                  v2_r, on2_r, done2_r;
  logic [ADDR_BITS-1:0]  prod2_r, xoff2_r;
  logic [COLOR_BITS-1:0] color2_r;

  logic                 fire, done, credit, on;
  logic [PB-1:0]        pending;
  logic signed [CW-1:0] x0, x1, y1;
  logic signed [EW:0]   e2, neg_sdy, sdx_w;
  logic [EW-1:0]        sdx_e, sdy_e;
  logic                 step_x, step_y, line_end;
  logic [DIM_BITS+PITCH_BITS-1:0] prod;

  // Results already in flight count against the result queue.
  assign pending = PB'(res_count) + PB'(v1_r) + PB'(v2_r);
  assign credit  = pending < PB'(RES_DEPTH);

  // Span of the running segment.
  always_comb begin
    x0 = org_x_r;
    x1 = far_x_r;
    y1 = far_y_r;
    if (mode_r == MODE_OUTLINE) begin
      unique case (seg_r)
        SEG_TOP:    y1 = org_y_r;
        SEG_BOTTOM: begin
        end
        SEG_LEFT:   x1 = org_x_r;
        SEG_RIGHT:  x0 = far_x_r;
        default: begin
        end
      endcase
    end
  end

  assign sdx_e    = {{(EW-COORD_BITS){1'b0}}, sdx_r};
  assign sdy_e    = {{(EW-COORD_BITS){1'b0}}, sdy_r};
  assign e2       = {err_r, 1'b0};
  assign sdx_w    = {1'b0, sdx_e};
  assign neg_sdy  = -{1'b0, sdy_e};
  assign step_x   = e2 > neg_sdy;
  assign step_y   = e2 < sdx_w;
  assign line_end = (cur_x_r == far_x_r) && (cur_y_r == far_y_r);

  assign on = !cur_x_r[CW-1] && !cur_y_r[CW-1]
              && ($unsigned(cur_x_r) < CW'(cfg.width))
              && ($unsigned(cur_y_r) < CW'(cfg.height));

  always_comb begin
    mode_nxt  = mode_r;
    seg_nxt   = seg_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    org_x_nxt = org_x_r;
    org_y_nxt = org_y_r;
    far_x_nxt = far_x_r;
    far_y_nxt = far_y_r;
    sdx_nxt   = sdx_r;
    sdy_nxt   = sdy_r;
    signs_nxt = signs_r;
    err_nxt   = err_r;
    hpos_nxt  = hpos_r;
    color_nxt = color_r;
    q_pop     = 1'b0;
    fire      = 1'b0;
    done      = 1'b0;

    if (q_valid) begin
      if (!q_ctl.is_tick) begin
        // Load a new command over whatever is running.
        q_pop     = 1'b1;
        mode_nxt  = q_ctl.mode;
        seg_nxt   = q_ctl.first_seg;
        cur_x_nxt = q_ax;
        cur_y_nxt = q_ay;
        org_x_nxt = q_ax;
        org_y_nxt = q_ay;
        far_x_nxt = q_bx;
        far_y_nxt = q_by;
        sdx_nxt   = q_sdx;
        sdy_nxt   = q_sdy;
        signs_nxt = q_ctl.signs;
        hpos_nxt  = q_ctl.hpos;
        color_nxt = q_color;
        err_nxt   = $signed({{(EW-COORD_BITS){1'b0}}, q_sdx})
                    - $signed({{(EW-COORD_BITS){1'b0}}, q_sdy});
      end else if (mode_r == MODE_IDLE) begin
        q_pop = 1'b1;
      end else if (credit) begin
        q_pop = 1'b1;
        fire  = 1'b1;
        if (mode_r == MODE_LINE) begin
          if (line_end) begin
            done = 1'b1;
          end else begin
            err_nxt = err_r - (step_x ? $signed(sdy_e) : '0)
                            + (step_y ? $signed(sdx_e) : '0);
            if (step_x) begin
              cur_x_nxt = signs_r[0] ? cur_x_r - ONE : cur_x_r + ONE;
            end
            if (step_y) begin
              cur_y_nxt = signs_r[1] ? cur_y_r - ONE : cur_y_r + ONE;
            end
          end
        end else if (cur_x_r != x1) begin
          cur_x_nxt = cur_x_r + ONE;
        end else begin
          cur_x_nxt = x0;
          if (cur_y_r != y1) begin
            cur_y_nxt = cur_y_r + ONE;
          end else if (mode_r == MODE_OUTLINE) begin
            unique case (seg_r)
              SEG_TOP: begin
                seg_nxt   = SEG_BOTTOM;
                cur_x_nxt = org_x_r;
                cur_y_nxt = far_y_r;
              end
              SEG_BOTTOM: begin
                if (hpos_r) begin
                  seg_nxt   = SEG_LEFT;
                  cur_x_nxt = org_x_r;
                  cur_y_nxt = org_y_r;
                end else begin
                  done = 1'b1;
                end
              end
              SEG_LEFT: begin
                seg_nxt   = SEG_RIGHT;
                cur_x_nxt = far_x_r;
                cur_y_nxt = org_y_r;
              end
              SEG_RIGHT: done = 1'b1;
              default:   done = 1'b1;
            endcase
          end else begin
            done = 1'b1;
          end
        end
        if (done) begin
          mode_nxt = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      seg_r  <= SEG_TOP;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      seg_r  <= seg_nxt;
      v1_r   <= fire;
      v2_r   <= v1_r;
    end
  end

  assign prod = py1_r * cfg.pitch;

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    org_x_r  <= org_x_nxt;
    org_y_r  <= org_y_nxt;
    far_x_r  <= far_x_nxt;
    far_y_r  <= far_y_nxt;
    sdx_r    <= sdx_nxt;
    sdy_r    <= sdy_nxt;
    signs_r  <= signs_nxt;
    err_r    <= err_nxt;
    hpos_r   <= hpos_nxt;
    color_r  <= color_nxt;
    // Candidate stage
    on1_r    <= on;
    done1_r  <= done;
    px1_r    <= cur_x_r[DIM_BITS-1:0];
    py1_r    <= cur_y_r[DIM_BITS-1:0];
    color1_r <= color_r;
    // Row offset stage
    on2_r    <= on1_r;
    done2_r  <= done1_r;
    prod2_r  <= ADDR_BITS'(prod);
    xoff2_r  <= ADDR_BITS'(px1_r) << PIX_SHIFT;
    color2_r <= color1_r;
  end

  assign res_valid         = v2_r;
  assign res.write_enable  = on2_r;
  assign res.pixel_address = on2_r ? cfg.base + prod2_r + xoff2_r : '0;
  assign res.pixel_color   = color2_r;
  assign res.done_res      = done2_r;

endmodule

// ===== design/raster_draw_engine.sv =====
// Channel  | Handshake                    | Payload
// ---------+------------------------------+------------------------------------------
// input    | in_push / in_full            | in_kind, in_start_x/y, in_end_x/y,
//          |                              | in_extent_w/h, in_paint
// result   | out_pop / out_empty          | out_write_enable, out_pixel_address,
//          |                              | out_pixel_color, out_done_res
// config   | cfg_we, cfg_index, cfg_wdata | fb_base, fb_width, fb_height, row_pitch
//
// One transaction per cycle in both directions unless a queue is full or empty;
// a tick's pixel takes a walker step, then a row-offset multiply, to the result side.
// The walker does one Bresenham or raster step per cycle while a tick is queued
// and a 4-entry result queue, which bounds the pixels in flight or waiting, has room.
// rst_n is synchronous: it empties both queues, idles the walker and reloads the
// registers with their defaults.
// in_full rises when the 2-entry command queue fills behind a stalled result side.
module raster_draw_engine #(
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic [rde_pkg::KIND_BITS-1:0]          in_kind,
  input  logic signed [COORD_BITS-1:0]           in_start_x,
  input  logic signed [COORD_BITS-1:0]           in_start_y,
  input  logic signed [COORD_BITS-1:0]           in_end_x,
  input  logic signed [COORD_BITS-1:0]           in_end_y,
  input  logic signed [COORD_BITS-1:0]           in_extent_w,
  input  logic signed [COORD_BITS-1:0]           in_extent_h,
  input  logic [rde_pkg::COLOR_BITS-1:0]         in_paint,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic                                   out_write_enable,
  output logic [rde_pkg::ADDR_BITS-1:0]          out_pixel_address,
  output logic [rde_pkg::COLOR_BITS-1:0]         out_pixel_color,
  output logic                                   out_done_res,
  input  logic                                   cfg_we,
  input  logic [rde_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [rde_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  import rde_pkg::*;

  localparam int CW       = COORD_BITS + 2;
  localparam int REC_BITS = $bits(rec_ctl_t) + COLOR_BITS + 4 * CW + 2 * COORD_BITS;

  cfg_t cfg_r;

  rec_ctl_t              f_ctl, q_ctl;
  logic [COLOR_BITS-1:0] f_color, q_color;
  logic signed [CW-1:0]  f_ax, f_ay, f_bx, f_by;
  logic signed [CW-1:0]  q_ax, q_ay, q_bx, q_by;
  logic [COORD_BITS-1:0] f_sdx, f_sdy, q_sdx, q_sdy;
  logic [REC_BITS-1:0]   f_rec, q_rec;
  logic                  q_empty, q_pop;

  res_t                  b_res, o_res;
  logic                  b_valid;
  logic [RES_CNT_BITS-1:0] res_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base   <= '0;
      cfg_r.width  <= DIM_BITS'(640);
      cfg_r.height <= DIM_BITS'(480);
      cfg_r.pitch  <= PITCH_BITS'(2560);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FB_BASE:   cfg_r.base   <= cfg_wdata[ADDR_BITS-1:0];
        REG_FB_WIDTH:  cfg_r.width  <= cfg_wdata[DIM_BITS-1:0];
        REG_FB_HEIGHT: cfg_r.height <= cfg_wdata[DIM_BITS-1:0];
        REG_ROW_PITCH: cfg_r.pitch  <= cfg_wdata[PITCH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rde_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .kind     (in_kind),
    .start_x  (in_start_x),
    .start_y  (in_start_y),
    .end_x    (in_end_x),
    .end_y    (in_end_y),
    .extent_w (in_extent_w),
    .extent_h (in_extent_h),
    .paint    (in_paint),
    .cfg      (cfg_r),
    .ctl      (f_ctl),
    .color    (f_color),
    .ax       (f_ax),
    .ay       (f_ay),
    .bx       (f_bx),
    .by       (f_by),
    .sdx      (f_sdx),
    .sdy      (f_sdy)
  );

  assign f_rec = {f_ctl, f_color, f_ax, f_ay, f_bx, f_by, f_sdx, f_sdy};
  assign {q_ctl, q_color, q_ax, q_ay, q_bx, q_by, q_sdx, q_sdy} = q_rec;

  rde_fifo #(
    .WIDTH(REC_BITS),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (f_rec),
    .full    (in_full),
    .pop     (q_pop),
    .rd_data (q_rec),
    .empty   (q_empty),
    .count   ()
  );

  rde_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (!q_empty),
    .q_ctl     (q_ctl),
    .q_color   (q_color),
    .q_ax      (q_ax),
    .q_ay      (q_ay),
    .q_bx      (q_bx),
    .q_by      (q_by),
    .q_sdx     (q_sdx),
    .q_sdy     (q_sdy),
    .q_pop     (q_pop),
    .res_count (res_count),
    .res_valid (b_valid),
    .res       (b_res)
  );

  rde_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (b_valid),
    .wr_data (b_res),
    .full    (),
    .pop     (out_pop),
    .rd_data (o_res),
    .empty   (out_empty),
    .count   (res_count)
  );

  assign out_write_enable  = o_res.write_enable;
  assign out_pixel_address = o_res.pixel_address;
  assign out_pixel_color   = o_res.pixel_color;
  assign out_done_res      = o_res.done_res;

endmodule

// ===== design/rde_checker.sv =====
`include "raster_draw_engine_assert.svh"

module rde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_write_enable,
  input logic [31:0] out_pixel_address,
  input logic [31:0] out_pixel_color,
  input logic        out_done_res
);

  logic        out_stall;
  logic        out_offscreen;
  logic [65:0] out_word;

  assign out_stall     = !out_empty && !out_pop;
  assign out_offscreen = !out_empty && !out_write_enable;
  assign out_word      = {out_write_enable, out_pixel_address, out_pixel_color, out_done_res};

  `RDE_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, !out_empty)
  `RDE_ASSERT_NXT(a_out_steady, clk, rst_n, out_stall, $stable(out_word))
  `RDE_ASSERT_IMP(a_clip_zero, clk, rst_n, out_offscreen, out_pixel_address == 32'd0)
  `RDE_ASSERT_RST(a_reset_drain, clk, !rst_n, out_empty && !in_full)

endmodule

bind raster_draw_engine rde_checker u_rde_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_write_enable  (out_write_enable),
  .out_pixel_address (out_pixel_address),
  .out_pixel_color   (out_pixel_color),
  .out_done_res      (out_done_res)
);
